[src/buddy_page_allocator_assert.svh]
// Assertion macros for the allocator RTL
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define BPA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define BPA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bpa_pkg.sv]
`default_nettype none
package bpa_pkg;

    // Fixed field widths of the request and result
    localparam int SIZE_W  = 23;
    localparam int ADDR_W  = 22;
    localparam int LEVEL_W = 3;
    localparam int STAT_W  = 2;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_BLOCK  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd2;

    // Link memory port controls
    typedef struct packed {
        logic re;
        logic we_next;
        logic we_prev;
    } t_lmem_ctl;

    // Frame memory port controls
    typedef struct packed {
        logic re;
        logic we_alloc;
        logic we_mark;
    } t_fmem_ctl;

    // One result
    typedef struct packed {
        logic [ADDR_W-1:0]  grant_address;
        logic [LEVEL_W-1:0] grant_level;
        logic [STAT_W-1:0]  status;
    } t_result;

endpackage
`default_nettype wire

[src/bpa_if.sv]
`default_nettype none
// Request channel
interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [bpa_pkg::SIZE_W-1:0]  req_size;
    logic [bpa_pkg::ADDR_W-1:0]  req_address;

    modport source (output valid, req_type, req_size, req_address, input ready);
    modport sink   (input valid, req_type, req_size, req_address, output ready);
endinterface

// Result channel
interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::ADDR_W-1:0]   grant_address;
    logic [bpa_pkg::LEVEL_W-1:0]  grant_level;
    logic [bpa_pkg::STAT_W-1:0]   status;

    modport source (output valid, grant_address, grant_level, status, input ready);
    modport sink   (input valid, grant_address, grant_level, status, output ready);
endinterface
`default_nettype wire

[src/bpa_link_mem.sv]
`default_nettype none
// Per-frame free-list links {next, prev}, one write and one registered read port
module bpa_link_mem #(
    parameter int DEPTH = 1024,
    parameter int FW    = 10
) (
    input  wire logic               i_clk,
    input  wire bpa_pkg::t_lmem_ctl i_ctl,
    input  wire logic [FW-1:0]      i_raddr,
    input  wire logic [FW-1:0]      i_waddr,
    input  wire logic [FW-1:0]      i_wnext,
    input  wire logic [FW-1:0]      i_wprev,
    output logic [FW-1:0]           o_rnext,
    output logic [FW-1:0]           o_rprev
);

    logic [2*FW-1:0] r_mem [DEPTH];
    logic [2*FW-1:0] r_rdata;

    // Field writes, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_next) begin
            r_mem[i_waddr][2*FW-1:FW] <= i_wnext;
        end
        if (i_ctl.we_prev) begin
            r_mem[i_waddr][FW-1:0] <= i_wprev;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rnext = r_rdata[2*FW-1:FW];
    assign o_rprev = r_rdata[FW-1:0];

endmodule
`default_nettype wire

[src/bpa_frame_mem.sv]
`default_nettype none
// Per-frame allocation level and per-level free marks, bit-maskable mark writes
module bpa_frame_mem #(
    parameter int DEPTH  = 1024,
    parameter int FW     = 10,
    parameter int AW     = 3,
    parameter int LEVELS = 7
) (
    input  wire logic               i_clk,
    input  wire bpa_pkg::t_fmem_ctl i_ctl,
    input  wire logic [FW-1:0]      i_raddr,
    input  wire logic [FW-1:0]      i_waddr,
    input  wire logic [AW-1:0]      i_walloc,
    input  wire logic [LEVELS-1:0]  i_wmask,
    input  wire logic [LEVELS-1:0]  i_wmark,
    output logic [AW-1:0]           o_ralloc,
    output logic [LEVELS-1:0]       o_rmark
);

    logic [AW+LEVELS-1:0] r_mem [DEPTH];
    logic [AW+LEVELS-1:0] r_rdata;

    // Level field and masked mark bits, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_alloc) begin
            r_mem[i_waddr][AW+LEVELS-1:LEVELS] <= i_walloc;
        end
        if (i_ctl.we_mark) begin
            for (int i = 0; i < LEVELS; i++) begin
                if (i_wmask[i]) begin
                    r_mem[i_waddr][i] <= i_wmark[i];
                end
            end
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_ralloc = r_rdata[AW+LEVELS-1:LEVELS];
    assign o_rmark  = r_rdata[LEVELS-1:0];

endmodule
`default_nettype wire

[src/bpa_ctrl.sv]
`default_nettype none
`include "buddy_page_allocator_assert.svh"
// Request sequencer: level scan, split, merge and list maintenance
module bpa_ctrl #(
    parameter int PAGE_BYTES  = 4096,
    parameter int FRAME_COUNT = 1024,
    parameter int TOP_LEVEL   = 6,
    localparam int LEVELS     = TOP_LEVEL + 1,
    localparam int FW         = $clog2(FRAME_COUNT),
    localparam int AW         = $clog2(TOP_LEVEL + 2)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request side
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire logic                         i_req_type,
    input  wire logic [bpa_pkg::SIZE_W-1:0]   i_req_size,
    input  wire logic [bpa_pkg::ADDR_W-1:0]   i_req_address,
    // result side
    input  wire logic                         i_slot_free,
    output logic                              o_res_valid,
    output bpa_pkg::t_result                  o_res,
    // link memory
    output bpa_pkg::t_lmem_ctl                o_lctl,
    output logic [FW-1:0]                     o_lraddr,
    output logic [FW-1:0]                     o_lwaddr,
    output logic [FW-1:0]                     o_lwnext,
    output logic [FW-1:0]                     o_lwprev,
    input  wire logic [FW-1:0]                i_lrnext,
    input  wire logic [FW-1:0]                i_lrprev,
    // frame memory
    output bpa_pkg::t_fmem_ctl                o_fctl,
    output logic [FW-1:0]                     o_fraddr,
    output logic [FW-1:0]                     o_fwaddr,
    output logic [AW-1:0]                     o_fwalloc,
    output logic [LEVELS-1:0]                 o_fwmask,
    output logic [LEVELS-1:0]                 o_fwmark,
    input  wire logic [AW-1:0]                i_fralloc,
    input  wire logic [LEVELS-1:0]            i_frmark
);

    localparam int LW      = $clog2(LEVELS);
    localparam int CW      = $clog2(FRAME_COUNT + 1);
    localparam int XW      = ((FW > TOP_LEVEL) ? FW : TOP_LEVEL) + 2;
    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int TOPS    = FRAME_COUNT >> TOP_LEVEL;
    localparam int TAIL0   = (TOPS > 0) ? (TOPS - 1) * (1 << TOP_LEVEL) : 0;

    localparam logic [XW-1:0]     BLK_TOP  = XW'(1) << TOP_LEVEL;
    localparam logic [LEVELS-1:0] TOP_MARK = LEVELS'(1) << TOP_LEVEL;
    localparam logic [LW-1:0]     LVL_TOP  = LW'(TOP_LEVEL);

    // Sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_UNL_RD   = 4'd3;
    localparam logic [3:0] S_UNL_EVAL = 4'd4;
    localparam logic [3:0] S_UNL_FIX  = 4'd5;
    localparam logic [3:0] S_SPLIT    = 4'd6;
    localparam logic [3:0] S_PUSH     = 4'd7;
    localparam logic [3:0] S_PUSH2    = 4'd8;
    localparam logic [3:0] S_FCHK     = 4'd9;
    localparam logic [3:0] S_MRG_CHK  = 4'd10;
    localparam logic [3:0] S_MRG_RD   = 4'd11;
    localparam logic [3:0] S_MRG_U2   = 4'd12;
    localparam logic [3:0] S_MRG_UP   = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    // Where a list push or unlink returns to
    localparam logic [1:0] RET_SPLIT = 2'd0;
    localparam logic [1:0] RET_MERGE = 2'd1;
    localparam logic [1:0] RET_MU1   = 2'd2;
    localparam logic [1:0] RET_MU2   = 2'd3;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_ret, n_ret;
    logic [LW-1:0]     r_want, n_want;
    logic [LW-1:0]     r_cur, n_cur;
    logic [FW-1:0]     r_frame, n_frame;
    logic [FW-1:0]     r_bud, n_bud;
    logic [FW-1:0]     r_tgt, n_tgt;
    logic [FW-1:0]     r_clr, n_clr;
    bpa_pkg::t_result  r_res, n_res;
    logic [FW-1:0]     r_head [LEVELS];
    logic [FW-1:0]     n_head [LEVELS];
    logic [FW-1:0]     r_tail [LEVELS];
    logic [FW-1:0]     n_tail [LEVELS];
    logic [CW-1:0]     r_cnt  [LEVELS];
    logic [CW-1:0]     n_cnt  [LEVELS];

    logic [CW-1:0]     cnt_cur;
    logic [FW-1:0]     head_cur;
    logic [FW-1:0]     tail_cur;
    logic [3:0]        ret_state;
    logic [LW-1:0]     size_lvl;
    logic [bpa_pkg::ADDR_W-1:0] addr_frame;
    logic              addr_bad;
    logic [XW-1:0]     clr_x;
    logic [XW-1:0]     clr_blk;
    logic              clr_top;
    logic [XW-1:0]     cur_span;
    logic [XW-1:0]     bud_x;
    logic              bud_fits;
    logic [LW-1:0]     lower;
    logic [AW-1:0]     fr_lvl;
    logic [LW-1:0]     free_lvl;

    // Smallest level whose block holds the size, clamped at the top
    function automatic logic [LW-1:0] f_size_level(input logic [bpa_pkg::SIZE_W-1:0] size);
        logic [LW-1:0] lv;
        lv = '0;
        for (int l = 0; l < TOP_LEVEL; l++) begin
            if ((64'(PAGE_BYTES) << l) < 64'(size)) begin
                lv = lv + LW'(1);
            end
        end
        return lv;
    endfunction

    // Per-level list registers seen at the current level
    assign cnt_cur  = r_cnt[r_cur];
    assign head_cur = r_head[r_cur];
    assign tail_cur = r_tail[r_cur];

    assign size_lvl   = f_size_level(i_req_size);
    assign addr_frame = i_req_address >> PAGE_SH;
    assign addr_bad   = 32'(addr_frame) >= 32'(FRAME_COUNT);

    // Reset image of one frame during the clearing pass
    assign clr_x   = XW'(r_clr);
    assign clr_blk = clr_x >> TOP_LEVEL;
    assign clr_top = ((clr_x & (BLK_TOP - XW'(1))) == '0) && (clr_blk < XW'(TOPS));

    // Buddy of the current block and whether it lies inside the pool
    assign cur_span = XW'(1) << r_cur;
    assign bud_x    = XW'(r_frame) ^ cur_span;
    assign bud_fits = (bud_x + cur_span) <= XW'(FRAME_COUNT);

    assign lower  = r_cur - LW'(1);
    assign fr_lvl = i_fralloc - AW'(1);
    assign free_lvl = (fr_lvl > AW'(TOP_LEVEL)) ? LVL_TOP : LW'(fr_lvl);

    // Return dispatch
    always_comb begin
        case (r_ret)
            RET_SPLIT: ret_state = S_SPLIT;
            RET_MERGE: ret_state = S_MRG_CHK;
            RET_MU1:   ret_state = S_MRG_U2;
            RET_MU2:   ret_state = S_MRG_UP;
            default:   ret_state = S_DONE;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_want  = r_want;
        n_cur   = r_cur;
        n_frame = r_frame;
        n_bud   = r_bud;
        n_tgt   = r_tgt;
        n_clr   = r_clr;
        n_res   = r_res;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_lctl      = '0;
        o_lraddr    = '0;
        o_lwaddr    = '0;
        o_lwnext    = '0;
        o_lwprev    = '0;
        o_fctl      = '0;
        o_fraddr    = '0;
        o_fwaddr    = '0;
        o_fwalloc   = '0;
        o_fwmask    = '0;
        o_fwmark    = '0;

        case (r_state)
            S_CLEAR: begin
                o_lctl.we_next  = 1'b1;
                o_lctl.we_prev  = 1'b1;
                o_lwaddr        = r_clr;
                o_lwnext        = (clr_top && (clr_blk + XW'(1) < XW'(TOPS))) ?
                                  FW'(clr_x + BLK_TOP) : '0;
                o_lwprev        = (clr_top && (clr_blk != '0)) ? FW'(clr_x - BLK_TOP) : '0;
                o_fctl.we_alloc = 1'b1;
                o_fctl.we_mark  = 1'b1;
                o_fwaddr        = r_clr;
                o_fwalloc       = '0;
                o_fwmask        = '1;
                o_fwmark        = clr_top ? TOP_MARK : '0;
                if (r_clr == FW'(FRAME_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + FW'(1);
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_type == bpa_pkg::REQ_ALLOC) begin
                        n_want  = size_lvl;
                        n_cur   = size_lvl;
                        n_state = S_SCAN;
                    end else begin
                        n_frame = FW'(addr_frame);
                        if (addr_bad) begin
                            n_res   = '{grant_address: '0, grant_level: '0,
                                        status: bpa_pkg::STAT_NOT_ALLOC};
                            n_state = S_DONE;
                        end else begin
                            o_fctl.re = 1'b1;
                            o_fraddr  = FW'(addr_frame);
                            n_state   = S_FCHK;
                        end
                    end
                end
            end
            // first non-empty level at or above the wanted one
            S_SCAN: begin
                if (cnt_cur != '0) begin
                    n_frame        = head_cur;
                    n_tgt          = head_cur;
                    o_fctl.we_mark = 1'b1;
                    o_fwaddr       = head_cur;
                    o_fwmask       = LEVELS'(1) << r_cur;
                    o_fwmark       = '0;
                    n_ret          = RET_SPLIT;
                    n_state        = S_UNL_RD;
                end else if (r_cur == LVL_TOP) begin
                    n_res   = '{grant_address: '0, grant_level: '0,
                                status: bpa_pkg::STAT_NO_BLOCK};
                    n_state = S_DONE;
                end else begin
                    n_cur = r_cur + LW'(1);
                end
            end
            // unlink r_tgt from the list of level r_cur
            S_UNL_RD: begin
                if (cnt_cur == '0) begin
                    n_state = ret_state;
                end else if (cnt_cur == CW'(1)) begin
                    n_cnt[r_cur] = cnt_cur - CW'(1);
                    n_state      = ret_state;
                end else begin
                    o_lctl.re = 1'b1;
                    o_lraddr  = r_tgt;
                    n_state   = S_UNL_EVAL;
                end
            end
            S_UNL_EVAL: begin
                n_cnt[r_cur] = cnt_cur - CW'(1);
                if (r_tgt == head_cur) begin
                    n_head[r_cur] = i_lrnext;
                    n_state       = ret_state;
                end else if (r_tgt == tail_cur) begin
                    n_tail[r_cur] = i_lrprev;
                    n_state       = ret_state;
                end else begin
                    o_lctl.we_next = 1'b1;
                    o_lwaddr       = i_lrprev;
                    o_lwnext       = i_lrnext;
                    n_state        = S_UNL_FIX;
                end
            end
            S_UNL_FIX: begin
                o_lctl.we_prev = 1'b1;
                o_lwaddr       = i_lrnext;
                o_lwprev       = i_lrprev;
                n_state        = ret_state;
            end
            // split down, queueing upper halves
            S_SPLIT: begin
                if (r_cur > r_want) begin
                    o_fctl.we_mark = 1'b1;
                    o_fwaddr       = FW'(XW'(r_frame) + (XW'(1) << lower));
                    o_fwmask       = LEVELS'(1) << lower;
                    o_fwmark       = '1;
                    n_tgt          = FW'(XW'(r_frame) + (XW'(1) << lower));
                    n_cur          = lower;
                    n_ret          = RET_SPLIT;
                    n_state        = S_PUSH;
                end else begin
                    o_fctl.we_alloc = 1'b1;
                    o_fwaddr        = r_frame;
                    o_fwalloc       = AW'(r_want) + AW'(1);
                    n_res           = '{grant_address: bpa_pkg::ADDR_W'(32'(r_frame) << PAGE_SH),
                                        grant_level: bpa_pkg::LEVEL_W'(r_want),
                                        status: bpa_pkg::STAT_OK};
                    n_state         = S_DONE;
                end
            end
            // append r_tgt to the list of level r_cur
            S_PUSH: begin
                if (cnt_cur == '0) begin
                    n_head[r_cur] = r_tgt;
                    n_tail[r_cur] = r_tgt;
                    n_cnt[r_cur]  = cnt_cur + CW'(1);
                    n_state       = ret_state;
                end else begin
                    o_lctl.we_next = 1'b1;
                    o_lwaddr       = tail_cur;
                    o_lwnext       = r_tgt;
                    n_state        = S_PUSH2;
                end
            end
            S_PUSH2: begin
                o_lctl.we_prev = 1'b1;
                o_lwaddr       = r_tgt;
                o_lwprev       = tail_cur;
                n_tail[r_cur]  = r_tgt;
                n_cnt[r_cur]   = cnt_cur + CW'(1);
                n_state        = ret_state;
            end
            // free: recorded level of the frame
            S_FCHK: begin
                if (i_fralloc == '0) begin
                    n_res   = '{grant_address: '0, grant_level: '0,
                                status: bpa_pkg::STAT_NOT_ALLOC};
                    n_state = S_DONE;
                end else begin
                    n_cur           = free_lvl;
                    o_fctl.we_alloc = 1'b1;
                    o_fctl.we_mark  = 1'b1;
                    o_fwaddr        = r_frame;
                    o_fwalloc       = '0;
                    o_fwmask        = LEVELS'(1) << free_lvl;
                    o_fwmark        = '1;
                    n_tgt           = r_frame;
                    n_ret           = RET_MERGE;
                    n_res           = '{grant_address: '0,
                                        grant_level: bpa_pkg::LEVEL_W'(free_lvl),
                                        status: bpa_pkg::STAT_OK};
                    n_state         = S_PUSH;
                end
            end
            // merge with a free buddy, one level per pass
            S_MRG_CHK: begin
                if ((r_cur == LVL_TOP) || !bud_fits) begin
                    n_state = S_DONE;
                end else begin
                    o_fctl.re = 1'b1;
                    o_fraddr  = FW'(bud_x);
                    n_bud     = FW'(bud_x);
                    n_state   = S_MRG_RD;
                end
            end
            S_MRG_RD: begin
                if (!i_frmark[r_cur]) begin
                    n_state = S_DONE;
                end else begin
                    o_fctl.we_mark = 1'b1;
                    o_fwaddr       = r_frame;
                    o_fwmask       = LEVELS'(1) << r_cur;
                    o_fwmark       = '0;
                    n_tgt          = r_frame;
                    n_ret          = RET_MU1;
                    n_state        = S_UNL_RD;
                end
            end
            S_MRG_U2: begin
                o_fctl.we_mark = 1'b1;
                o_fwaddr       = r_bud;
                o_fwmask       = LEVELS'(1) << r_cur;
                o_fwmark       = '0;
                n_tgt          = r_bud;
                n_ret          = RET_MU2;
                n_state        = S_UNL_RD;
            end
            S_MRG_UP: begin
                o_fctl.we_mark = 1'b1;
                o_fwaddr       = FW'(XW'(r_frame) & ~cur_span);
                o_fwmask       = LEVELS'(1) << (r_cur + LW'(1));
                o_fwmark       = '1;
                n_frame        = FW'(XW'(r_frame) & ~cur_span);
                n_tgt          = FW'(XW'(r_frame) & ~cur_span);
                n_cur          = r_cur + LW'(1);
                n_ret          = RET_MERGE;
                n_state        = S_PUSH;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cur   <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= (l == TOP_LEVEL) ? FW'(TAIL0) : '0;
                r_cnt[l]  <= (l == TOP_LEVEL) ? CW'(TOPS) : '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cur   <= n_cur;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_want  <= n_want;
        r_frame <= n_frame;
        r_bud   <= n_bud;
        r_tgt   <= n_tgt;
        r_res   <= n_res;
    end

    assign o_res = r_res;

    `BPA_ASSERT_IMP(a_lmem_apart, i_clk, i_rst_n, o_lctl.re && (o_lctl.we_next || o_lctl.we_prev), o_lraddr != o_lwaddr, "link memory read and write collide")
    `BPA_ASSERT_IMP(a_fmem_apart, i_clk, i_rst_n, o_fctl.re && (o_fctl.we_alloc || o_fctl.we_mark), o_fraddr != o_fwaddr, "frame memory read and write collide")
    `BPA_ASSERT_IMP(a_level_range, i_clk, i_rst_n, 1'b1, r_cur <= LVL_TOP, "level out of range")
    `BPA_ASSERT_NXT(a_accept_leaves, i_clk, i_rst_n, (r_state == S_IDLE) && i_req_valid, r_state != S_IDLE, "request not taken")

endmodule
`default_nettype wire

[src/buddy_page_allocator.sv]
// Buddy page allocator over a pool of FRAME_COUNT frames of PAGE_BYTES bytes.
// i_req carries allocate (byte size) and free (byte address) requests; a request
// is taken when valid and ready are high at a clock edge. o_rsp returns one
// result per request: block address, level and status.
// Requests are handled one at a time, and the free lists are updated serially.
// The result shows on o_rsp in the cycle after the sequencer finishes.
// After reset a clearing pass writes every frame entry, during which no
// request is taken; then only the top-level blocks are free, listed in
// ascending order.
// Results sit in an output register: while the receiver stalls, the next
// request is still taken and worked on, and waits only for the register to
// empty before its own result is shown.
`default_nettype none
module buddy_page_allocator #(
    parameter int PAGE_BYTES  = 4096,
    parameter int FRAME_COUNT = 1024,
    parameter int TOP_LEVEL   = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp
);

    localparam int LEVELS = TOP_LEVEL + 1;
    localparam int FW     = $clog2(FRAME_COUNT);
    localparam int AW     = $clog2(TOP_LEVEL + 2);

    bpa_pkg::t_lmem_ctl lctl;
    bpa_pkg::t_fmem_ctl fctl;
    logic [FW-1:0]      lraddr, lwaddr, lwnext, lwprev, lrnext, lrprev;
    logic [FW-1:0]      fraddr, fwaddr;
    logic [AW-1:0]      fwalloc, fralloc;
    logic [LEVELS-1:0]  fwmask, fwmark, frmark;
    logic               slot_free;
    logic               res_valid;
    bpa_pkg::t_result   res;
    logic               r_valid;
    bpa_pkg::t_result   r_out;

    bpa_ctrl #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FRAME_COUNT (FRAME_COUNT),
        .TOP_LEVEL   (TOP_LEVEL)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_req_type    (i_req.req_type),
        .i_req_size    (i_req.req_size),
        .i_req_address (i_req.req_address),
        .i_slot_free   (slot_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_lctl        (lctl),
        .o_lraddr      (lraddr),
        .o_lwaddr      (lwaddr),
        .o_lwnext      (lwnext),
        .o_lwprev      (lwprev),
        .i_lrnext      (lrnext),
        .i_lrprev      (lrprev),
        .o_fctl        (fctl),
        .o_fraddr      (fraddr),
        .o_fwaddr      (fwaddr),
        .o_fwalloc     (fwalloc),
        .o_fwmask      (fwmask),
        .o_fwmark      (fwmark),
        .i_fralloc     (fralloc),
        .i_frmark      (frmark)
    );

    bpa_link_mem #(
        .DEPTH (FRAME_COUNT),
        .FW    (FW)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_ctl   (lctl),
        .i_raddr (lraddr),
        .i_waddr (lwaddr),
        .i_wnext (lwnext),
        .i_wprev (lwprev),
        .o_rnext (lrnext),
        .o_rprev (lrprev)
    );

    bpa_frame_mem #(
        .DEPTH  (FRAME_COUNT),
        .FW     (FW),
        .AW     (AW),
        .LEVELS (LEVELS)
    ) u_frame_mem (
        .i_clk    (i_clk),
        .i_ctl    (fctl),
        .i_raddr  (fraddr),
        .i_waddr  (fwaddr),
        .i_walloc (fwalloc),
        .i_wmask  (fwmask),
        .i_wmark  (fwmark),
        .o_ralloc (fralloc),
        .o_rmark  (frmark)
    );

    // Output register
    assign slot_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_valid) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.grant_address = r_out.grant_address;
    assign o_rsp.grant_level   = r_out.grant_level;
    assign o_rsp.status        = r_out.status;

endmodule
`default_nettype wire

[tb/sv/tb_buddy_page_allocator.sv]
`default_nettype none
// Allocation-table model and expected-grant queue
class buddy_scoreboard;
    localparam int PAGE   = 4096;
    localparam int FRAMES = 1024;
    localparam int TOP    = 6;

    bit         mark [0:TOP][0:FRAMES-1];
    int         nxt [0:FRAMES-1];
    int         prv [0:FRAMES-1];
    int         head [0:TOP];
    int         tail [0:TOP];
    int         cnt [0:TOP];
    int         alloc_lvl [0:FRAMES-1];
    bpa_pkg::t_result grants_due[$];
    int         fail_count;

    function new();
        for (int l = 0; l <= TOP; l++) begin
            cnt[l] = 0;
            head[l] = 0;
            tail[l] = 0;
            for (int f = 0; f < FRAMES; f++) mark[l][f] = 0;
        end
        for (int f = 0; f < FRAMES; f++) begin
            nxt[f] = 0;
            prv[f] = 0;
            alloc_lvl[f] = 0;
        end
        for (int b = 0; b < (FRAMES >> TOP); b++) begin
            mark[TOP][b] = 1;
            push_tail(TOP, b << TOP);
        end
        fail_count = 0;
    endfunction

    function void push_tail(int l, int f);
        if (cnt[l] == 0) begin
            head[l] = f;
        end else begin
            nxt[tail[l]] = f;
            prv[f] = tail[l];
        end
        tail[l] = f;
        cnt[l]++;
    endfunction

    function void unlink(int l, int f);
        if (cnt[l] == 0) return;
        if (cnt[l] > 1) begin
            if (f == head[l]) head[l] = nxt[f];
            else if (f == tail[l]) tail[l] = prv[f];
            else begin
                nxt[prv[f]] = nxt[f];
                prv[nxt[f]] = prv[f];
            end
        end
        cnt[l]--;
    endfunction

    // A random allocated frame, or -1 if none is allocated (used to steer stimulus)
    function int pick_allocated();
        int cands[$];
        for (int f = 0; f < FRAMES; f++) if (alloc_lvl[f] != 0) cands.push_back(f);
        if (cands.size() == 0) return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // Work out the result of one accepted request
    function void note_request(logic kind, logic [22:0] size, logic [21:0] addr);
        bpa_pkg::t_result r;
        int want, cur, f, blk, bud;
        r = '0;
        if (kind == bpa_pkg::REQ_ALLOC) begin
            want = 0;
            while (want < TOP && (longint'(PAGE) << want) < longint'(size)) want++;
            r.status = bpa_pkg::STAT_NO_BLOCK;
            for (cur = want; cur <= TOP; cur++) begin
                if (cnt[cur] != 0) begin
                    f = head[cur];
                    unlink(cur, f);
                    mark[cur][f >> cur] = 0;
                    while (cur > want) begin
                        cur--;
                        mark[cur][(f + (1 << cur)) >> cur] = 1;
                        push_tail(cur, f + (1 << cur));
                    end
                    alloc_lvl[f] = want + 1;
                    r.grant_address = f * PAGE;
                    r.grant_level = want;
                    r.status = bpa_pkg::STAT_OK;
                    break;
                end
            end
        end else begin
            f = addr / PAGE;
            if (f >= FRAMES || alloc_lvl[f] == 0) begin
                r.status = bpa_pkg::STAT_NOT_ALLOC;
            end else begin
                cur = alloc_lvl[f] - 1;
                if (cur > TOP) cur = TOP;
                alloc_lvl[f] = 0;
                r.grant_level = cur;
                blk = f >> cur;
                mark[cur][blk] = 1;
                push_tail(cur, blk << cur);
                while (cur < TOP) begin
                    bud = blk ^ 1;
                    if (bud >= (FRAMES >> cur) || !mark[cur][bud]) break;
                    mark[cur][blk] = 0;
                    unlink(cur, blk << cur);
                    mark[cur][bud] = 0;
                    unlink(cur, bud << cur);
                    blk >>= 1;
                    cur++;
                    mark[cur][blk] = 1;
                    push_tail(cur, blk << cur);
                end
            end
        end
        grants_due.push_back(r);
    endfunction

    function void report(string what, int got, int exp_v);
        $display("grant %s: got %0d, expected %0d", what, got, exp_v);
        fail_count++;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_grant(bpa_pkg::t_result got);
        bpa_pkg::t_result exp_r;
        if (grants_due.size() == 0) begin
            $display("grant with nothing outstanding");
            fail_count++;
            return;
        end
        exp_r = grants_due.pop_front();
        if (got.grant_address != exp_r.grant_address)
            report("address", got.grant_address, exp_r.grant_address);
        if (got.grant_level != exp_r.grant_level)
            report("level", got.grant_level, exp_r.grant_level);
        if (got.status != exp_r.status)
            report("status", got.status, exp_r.status);
    endfunction
endclass

module tb_buddy_page_allocator;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    buddy_scoreboard sb = new();
    bit  stim_done = 0;
    bit  hold_req = 0;
    bit  hold_off = 0;
    int  idle_cycles = 0;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    buddy_page_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.req_size = '0;
        req_ch.req_address = '0;
        rsp_ch.ready = 1'b0;
    end

    // Offer one request and wait for it to be taken; returns at a falling edge
    task automatic send_request(logic kind, logic [22:0] size, logic [21:0] addr);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.req_size <= size;
        req_ch.req_address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(kind, size, addr);
        @(negedge i_clk);
    endtask

    task automatic send_alloc(logic [22:0] size);
        send_request(bpa_pkg::REQ_ALLOC, size, $urandom());
    endtask

    task automatic send_free(logic [21:0] addr);
        send_request(bpa_pkg::REQ_FREE, $urandom(), addr);
    endtask

    // Mostly sizes of a few pages, now and then a large block
    function automatic logic [22:0] rand_size();
        int l;
        l = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: return 23'(4096 << l);
            1: return 23'((4096 << l) + 1);
            default: return 23'($urandom_range(0, 4096 << l));
        endcase
    endfunction

    // Stimulus
    initial begin
        int f;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: size extremes, oversize, bad frees
        send_alloc(23'd0);
        send_alloc(23'd1);
        send_alloc(23'd4096);
        send_alloc(23'd4097);
        send_alloc(23'd262144);
        send_alloc(23'd262145);
        send_alloc(23'h7FFFFF);
        send_alloc(23'd4194304);
        send_free(22'h3FFFFF);
        send_free(22'd4096 + 22'd5);
        send_free(22'd0);
        send_free(22'd0);
        send_free(22'd4096 * 2);
        send_free(22'h155555);
        send_free(22'h2AAAAA);
        // exhaust the pool, then free everything
        for (int i = 0; i < 20; i++) send_alloc(23'd262144);
        send_alloc(23'd0);
        while ((f = sb.pick_allocated()) >= 0) send_free(22'(f * 4096));
        // random mix
        for (int i = 0; i < 1300; i++) begin
            if (i == 400) hold_req = 1;
            f = sb.pick_allocated();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_alloc(rand_size());
                5, 6, 7: if (f >= 0) send_free(22'(f * 4096 + $urandom_range(0, 4095)));
                         else send_alloc(rand_size());
                8: if (f >= 0) send_free(22'(f * 4096));
                   else send_free($urandom());
                default: send_free($urandom());
            endcase
        end
        req_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // Long receiver hold-off, timed in cycles on its own
    initial begin
        wait (hold_req);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // Result side with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_off) rsp_ch.ready <= 1'b0;
        else if (idle_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            idle_cycles <= idle_cycles - 1;
        end else rsp_ch.ready <= 1'b1;
    end

    int stall_count = 0;
    int done_wait = 0;
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready && i_rst_n) begin
            sb.check_grant('{rsp_ch.grant_address, rsp_ch.grant_level, rsp_ch.status});
            if ($urandom_range(0, 2) != 0) idle_cycles <= $urandom_range(0, 8);
        end
        if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || hold_off)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > IDLE_LIMIT) begin
            $display("buddy_page_allocator: mismatch");
            $finish;
        end
        if (stim_done && sb.grants_due.size() == 0) begin
            done_wait <= done_wait + 1;
            if (done_wait == 100) begin
                if (sb.fail_count == 0) $display("buddy_page_allocator: match");
                else $display("buddy_page_allocator: mismatch");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
